// ===== src/hbd_pkg.sv =====
// Shared types and constants for the HTTP body dechunker.
package hbd_pkg;

   // Configuration port address width and register indexes.
   localparam int CSR_ADDR_WIDTH = 3;

   typedef enum logic {
      REG_CHUNKED_MODE   = 1'b0,
      REG_CONTENT_LENGTH = 1'b1
   } reg_index_type;

   // Framing characters.
   localparam logic [7:0] CHR_CR     = 8'h0D;
   localparam logic [7:0] CHR_LF     = 8'h0A;
   localparam logic [7:0] CHR_DIG_0  = 8'h30;
   localparam logic [7:0] CHR_DIG_9  = 8'h39;
   localparam logic [7:0] CHR_UP_A   = 8'h41;
   localparam logic [7:0] CHR_UP_F   = 8'h46;
   localparam logic [7:0] CHR_LO_A   = 8'h61;
   localparam logic [7:0] CHR_LO_F   = 8'h66;
   localparam logic [3:0] HEX_TEN    = 4'd10;

   // Decoder phase.
   typedef enum logic [2:0] {
      PH_LEN_DATA = 3'd0,
      PH_SIZE     = 3'd1,
      PH_SIZE_LF  = 3'd2,
      PH_DATA     = 3'd3,
      PH_DATA_CR  = 3'd4,
      PH_DATA_LF  = 3'd5,
      PH_DONE     = 3'd6
   } phase_type;

   // Error codes reported on the result channel.
   typedef enum logic [2:0] {
      ERR_NONE     = 3'd0,
      ERR_HEX      = 3'd1,
      ERR_SIZE_LF  = 3'd2,
      ERR_DATA_CR  = 3'd3,
      ERR_DATA_LF  = 3'd4,
      ERR_OVERFLOW = 3'd5,
      ERR_AFTER    = 3'd6
   } err_type;

   // One classified input byte as it travels from front to back.
   typedef struct packed {
      logic [7:0] data;
      logic       is_cr;
      logic       is_lf;
      logic       is_hex;
      logic [3:0] hex_val;
   } class_type;

   // Restart request with the register values that take effect.
   typedef struct packed {
      logic        restart;
      logic        chunked;
      logic [31:0] length;
   } cfg_type;

   // One result beat.
   typedef struct packed {
      logic       payload_valid;
      logic [7:0] payload_byte;
      logic       body_done;
      err_type    error_code;
   } result_type;

endpackage

// ===== src/http_body_dechunker.sv =====
// Top level of the HTTP body dechunker: register port and block wiring.
//
// Usage:
//   Body bytes enter one per beat on the req_ channel (req_valid, req_stall,
//   req_in_byte). Each byte gives exactly one result beat on the rsp_ channel:
//   payload flag and byte, body-done flag and error code.
//   Registers are written over the APB-style port: chunked_mode at byte
//   address 0 and content_length at byte address 4. Every write restarts the
//   decoder with the new values; write only while no beat is in flight.
//   Throughput is one byte per cycle while rsp_stall is low. A byte is held
//   in a two-entry queue, then the back-end state machine settles it into the
//   result register that drives rsp_valid.
//   When the receiver stalls, the result register holds and the queue fills;
//   req_stall rises once both queue entries are occupied.
//   Reset clears both registers, so the decoder starts in length mode with a
//   zero length, which means that any first byte reports byte after done.
//   Errors latch until the next register write.
module http_body_dechunker
   import hbd_pkg::*;
#(
   parameter int COUNT_WIDTH = 32
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [7:0]                req_in_byte,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_payload_valid,
   output logic [7:0]                rsp_payload_byte,
   output logic                      rsp_body_done,
   output logic [2:0]                rsp_error_code,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [31:0]               pwdata,
   output logic [31:0]               prdata,
   output logic                      pready
);

   logic          chunked_mode_ff, chunked_mode_in;
   logic [31:0]   content_length_ff, content_length_in;
   logic          csr_write;
   reg_index_type csr_index;
   cfg_type       cfg;

   logic          push;
   class_type     push_item;
   logic          queue_full;
   logic          queue_empty;
   logic          pop;
   class_type     pop_item;
   result_type    rsp;

   // Register port.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = reg_index_type'(paddr[2]);

   always_comb begin
      chunked_mode_in   = chunked_mode_ff;
      content_length_in = content_length_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_CHUNKED_MODE:   chunked_mode_in   = pwdata[0];
            REG_CONTENT_LENGTH: content_length_in = pwdata;
            default:            chunked_mode_in   = chunked_mode_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_CHUNKED_MODE:   prdata = {31'd0, chunked_mode_ff};
         REG_CONTENT_LENGTH: prdata = content_length_ff;
         default:            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chunked_mode_ff   <= 1'b0;
         content_length_ff <= '0;
      end else begin
         chunked_mode_ff   <= chunked_mode_in;
         content_length_ff <= content_length_in;
      end
   end

   // Restart request carries the values that take effect at the write.
   assign cfg.restart = csr_write;
   assign cfg.chunked = chunked_mode_in;
   assign cfg.length  = content_length_in;

   hbd_front u_front (
      .req_valid   (req_valid),
      .req_in_byte (req_in_byte),
      .req_stall   (req_stall),
      .queue_full  (queue_full),
      .push        (push),
      .push_item   (push_item)
   );

   hbd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   hbd_back #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .queue_empty (queue_empty),
      .item        (pop_item),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp         (rsp)
   );

   // Result beat fields.
   assign rsp_payload_valid = rsp.payload_valid;
   assign rsp_payload_byte  = rsp.payload_byte;
   assign rsp_body_done     = rsp.body_done;
   assign rsp_error_code    = rsp.error_code;

endmodule

// ===== src/hbd_front.sv =====
// Front end: accepts input beats and classifies each byte for the decoder.
module hbd_front
   import hbd_pkg::*;
(
   input  logic       req_valid,
   input  logic [7:0] req_in_byte,
   output logic       req_stall,
   input  logic       queue_full,
   output logic       push,
   output class_type  push_item
);

   // Accept whenever the queue has room.
   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   // Classify the byte: framing characters and hex digit value.
   always_comb begin
      push_item         = '0;
      push_item.data    = req_in_byte;
      push_item.is_cr   = (req_in_byte == CHR_CR);
      push_item.is_lf   = (req_in_byte == CHR_LF);
      if (req_in_byte >= CHR_DIG_0 && req_in_byte <= CHR_DIG_9) begin
         push_item.is_hex  = 1'b1;
         push_item.hex_val = 4'(req_in_byte - CHR_DIG_0);
      end else if (req_in_byte >= CHR_UP_A && req_in_byte <= CHR_UP_F) begin
         push_item.is_hex  = 1'b1;
         push_item.hex_val = 4'(req_in_byte - CHR_UP_A) + HEX_TEN;
      end else if (req_in_byte >= CHR_LO_A && req_in_byte <= CHR_LO_F) begin
         push_item.is_hex  = 1'b1;
         push_item.hex_val = 4'(req_in_byte - CHR_LO_A) + HEX_TEN;
      end
   end

endmodule

// ===== src/hbd_queue.sv =====
// Two-entry queue that decouples the front end from the decoder.
module hbd_queue
   import hbd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  class_type push_item,
   input  logic      pop,
   output class_type pop_item,
   output logic      full,
   output logic      empty
);

   class_type  entries_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_item = entries_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== src/hbd_back.sv =====
// Decoder back end: framing state machine, byte counter and result register.
module hbd_back
   import hbd_pkg::*;
#(
   parameter int COUNT_WIDTH = 32
)
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       queue_empty,
   input  class_type  item,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output result_type rsp
);

   phase_type              phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0] remaining_ff, remaining_in;
   err_type                error_ff, error_in;
   logic                   out_valid_ff, out_valid_in;
   result_type             out_ff, out_in;

   logic [COUNT_WIDTH-1:0] rem_dec;
   logic                   rem_dec_zero;
   logic                   rem_zero;
   logic                   rem_top_busy;
   logic [COUNT_WIDTH-1:0] len_count;
   logic                   len_wide;
   result_type             res;

   // Take a beat from the queue when the result register is free or draining.
   assign pop          = !queue_empty && (!out_valid_ff || !rsp_stall);
   assign out_valid_in = pop || (out_valid_ff && rsp_stall);
   assign out_in       = pop ? res : out_ff;

   assign rem_dec      = remaining_ff - COUNT_WIDTH'(1);
   assign rem_dec_zero = (rem_dec == '0);
   assign rem_zero     = (remaining_ff == '0);
   assign rem_top_busy = (remaining_ff[COUNT_WIDTH-1 -: 4] != 4'd0);

   // Content length clamped to the counter range.
   assign len_wide  = ((64'(cfg.length) >> COUNT_WIDTH) != 64'd0);
   assign len_count = len_wide ? '1 : COUNT_WIDTH'(cfg.length);

   // Result for the beat at the head of the queue.
   always_comb begin
      res = '0;
      res.error_code = ERR_NONE;
      if (error_ff != ERR_NONE) begin
         res.error_code = error_ff;
      end else begin
         unique case (phase_ff)
            PH_LEN_DATA: begin
               res.payload_valid = 1'b1;
               res.payload_byte  = item.data;
               res.body_done     = rem_dec_zero;
            end
            PH_SIZE: begin
               if (!item.is_cr) begin
                  if (!item.is_hex) begin
                     res.error_code = ERR_HEX;
                  end else if (rem_top_busy) begin
                     res.error_code = ERR_OVERFLOW;
                  end
               end
            end
            PH_SIZE_LF: begin
               if (!item.is_lf) begin
                  res.error_code = ERR_SIZE_LF;
               end else begin
                  res.body_done = rem_zero;
               end
            end
            PH_DATA: begin
               res.payload_valid = 1'b1;
               res.payload_byte  = item.data;
            end
            PH_DATA_CR: begin
               if (!item.is_cr) begin
                  res.error_code = ERR_DATA_CR;
               end
            end
            PH_DATA_LF: begin
               if (!item.is_lf) begin
                  res.error_code = ERR_DATA_LF;
               end
            end
            default: begin
               res.error_code = ERR_AFTER;
            end
         endcase
      end
   end

   // Next phase, counter and latched error.
   always_comb begin
      phase_in     = phase_ff;
      remaining_in = remaining_ff;
      error_in     = error_ff;
      if (cfg.restart) begin
         error_in = ERR_NONE;
         if (cfg.chunked) begin
            phase_in     = PH_SIZE;
            remaining_in = '0;
         end else begin
            remaining_in = len_count;
            phase_in     = (len_count == '0) ? PH_DONE : PH_LEN_DATA;
         end
      end else if (pop && error_ff == ERR_NONE) begin
         error_in = res.error_code;
         unique case (phase_ff)
            PH_LEN_DATA: begin
               remaining_in = rem_dec;
               if (rem_dec_zero) begin
                  phase_in = PH_DONE;
               end
            end
            PH_SIZE: begin
               if (item.is_cr) begin
                  phase_in = PH_SIZE_LF;
               end else if (item.is_hex) begin
                  if (rem_top_busy) begin
                     remaining_in = '1;
                  end else begin
                     remaining_in = {remaining_ff[COUNT_WIDTH-5:0], item.hex_val};
                  end
               end
            end
            PH_SIZE_LF: begin
               if (item.is_lf) begin
                  phase_in = rem_zero ? PH_DONE : PH_DATA;
               end
            end
            PH_DATA: begin
               remaining_in = rem_dec;
               if (rem_dec_zero) begin
                  phase_in = PH_DATA_CR;
               end
            end
            PH_DATA_CR: begin
               if (item.is_cr) begin
                  phase_in = PH_DATA_LF;
               end
            end
            PH_DATA_LF: begin
               if (item.is_lf) begin
                  phase_in     = PH_SIZE;
                  remaining_in = '0;
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_DONE;
         remaining_ff <= '0;
         error_ff     <= ERR_NONE;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         remaining_ff <= remaining_in;
         error_ff     <= error_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp       = out_ff;

   // A latched error holds until a restart.
   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      (error_ff != ERR_NONE && !cfg.restart) |=> (error_ff == $past(error_ff)))
      else $error("latched error changed without restart");

   // Once done, the decoder stays done until a restart.
   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DONE && !cfg.restart) |=> (phase_ff == PH_DONE))
      else $error("decoder left the done phase");

   // A held result is never overwritten by a new beat.
   a_no_pop_on_hold: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_stall) |-> !pop)
      else $error("queue popped while result was stalled");

   // Payload beats never carry an error.
   a_payload_clean: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.payload_valid) |-> (out_ff.error_code == ERR_NONE))
      else $error("payload beat flagged with an error");

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the HTTP body dechunker: directed and random byte streams.
`timescale 1ns / 1ps

module tb;
   import hbd_pkg::*;

   localparam int COUNT_WIDTH = 32;

   // Kinds of framing damage injected into chunked streams.
   typedef enum int {
      FLAW_NONE,
      FLAW_HEX,
      FLAW_SIZE_LF,
      FLAW_DATA_CR,
      FLAW_DATA_LF,
      FLAW_OVERFLOW
   } flaw_kind_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic [7:0]                req_in_byte;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic                      rsp_payload_valid;
   logic [7:0]                rsp_payload_byte;
   logic                      rsp_body_done;
   logic [2:0]                rsp_error_code;
   logic                      psel;
   logic                      penable;
   logic                      pwrite;
   logic [CSR_ADDR_WIDTH-1:0] paddr;
   logic [31:0]               pwdata;
   logic [31:0]               prdata;
   logic                      pready;

   // Value of a hex digit character, or -1 for any other byte.
   function automatic int hex_of(logic [7:0] b);
      if (b >= CHR_DIG_0 && b <= CHR_DIG_9) return int'(b - CHR_DIG_0);
      if (b >= CHR_UP_A && b <= CHR_UP_F) return int'(b - CHR_UP_A) + int'(HEX_TEN);
      if (b >= CHR_LO_A && b <= CHR_LO_F) return int'(b - CHR_LO_A) + int'(HEX_TEN);
      return -1;
   endfunction

   // Decoder state mirror plus the queue of result beats still owed by the block.
   class dechunk_scoreboard;
      logic                   chunked;
      logic [31:0]            length;
      phase_type              phase;
      logic [COUNT_WIDTH-1:0] remaining;
      err_type                latched;
      result_type             owed_beats[$];
      int unsigned            fail_count;

      function new();
         chunked    = 1'b0;
         length     = '0;
         fail_count = 0;
         restart();
      endfunction

      // Return to the start of a body with the current register values.
      function void restart();
         logic [63:0] cap;
         cap     = (64'd1 << COUNT_WIDTH) - 64'd1;
         latched = ERR_NONE;
         if (chunked) begin
            phase     = PH_SIZE;
            remaining = '0;
         end else begin
            remaining = (64'(length) > cap) ? '1 : COUNT_WIDTH'(length);
            phase     = (remaining == 0) ? PH_DONE : PH_LEN_DATA;
         end
      endfunction

      // A register write stores the value and restarts the decoder.
      function void set_reg(reg_index_type idx, logic [31:0] value);
         if (idx == REG_CHUNKED_MODE) chunked = value[0];
         else length = value;
         restart();
      endfunction

      // Decode one accepted byte and queue the result beat it must produce.
      function void note_byte(logic [7:0] b);
         result_type r;
         int         h;
         r = '0;
         r.error_code = ERR_NONE;
         if (latched != ERR_NONE) begin
            r.error_code = latched;
         end else begin
            case (phase)
               PH_LEN_DATA: begin
                  r.payload_valid = 1'b1;
                  r.payload_byte  = b;
                  remaining = remaining - 1'b1;
                  if (remaining == 0) begin
                     r.body_done = 1'b1;
                     phase = PH_DONE;
                  end
               end
               PH_SIZE: begin
                  if (b == CHR_CR) begin
                     phase = PH_SIZE_LF;
                  end else begin
                     h = hex_of(b);
                     if (h < 0) begin
                        r.error_code = ERR_HEX;
                     end else if (remaining[COUNT_WIDTH-1 -: 4] != 0) begin
                        remaining    = '1;
                        r.error_code = ERR_OVERFLOW;
                     end else begin
                        remaining = {remaining[COUNT_WIDTH-5:0], 4'(h)};
                     end
                  end
               end
               PH_SIZE_LF: begin
                  if (b != CHR_LF) begin
                     r.error_code = ERR_SIZE_LF;
                  end else if (remaining == 0) begin
                     r.body_done = 1'b1;
                     phase = PH_DONE;
                  end else begin
                     phase = PH_DATA;
                  end
               end
               PH_DATA: begin
                  r.payload_valid = 1'b1;
                  r.payload_byte  = b;
                  remaining = remaining - 1'b1;
                  if (remaining == 0) phase = PH_DATA_CR;
               end
               PH_DATA_CR: begin
                  if (b == CHR_CR) phase = PH_DATA_LF;
                  else r.error_code = ERR_DATA_CR;
               end
               PH_DATA_LF: begin
                  if (b == CHR_LF) begin
                     phase     = PH_SIZE;
                     remaining = '0;
                  end else begin
                     r.error_code = ERR_DATA_LF;
                  end
               end
               default: begin
                  r.error_code = ERR_AFTER;
               end
            endcase
            latched = r.error_code;
         end
         owed_beats.insert(owed_beats.size(), r);
      endfunction

      // Compare one accepted result beat with the oldest owed beat.
      function void match_beat(logic pv, logic [7:0] pb, logic bd, logic [2:0] ec);
         result_type e;
         if (owed_beats.size() == 0) begin
            $error("result beat with no byte outstanding");
            fail_count++;
            return;
         end
         e = owed_beats.pop_front();
         if (pv !== e.payload_valid) begin
            $error("payload_valid: expected %0d, actual %0d", e.payload_valid, pv);
            fail_count++;
         end
         if (pb !== e.payload_byte) begin
            $error("payload_byte: expected 0x%02h, actual 0x%02h", e.payload_byte, pb);
            fail_count++;
         end
         if (bd !== e.body_done) begin
            $error("body_done: expected %0d, actual %0d", e.body_done, bd);
            fail_count++;
         end
         if (ec !== e.error_code) begin
            $error("error_code: expected %0d, actual %0d", e.error_code, ec);
            fail_count++;
         end
      endfunction

      function int pending();
         return owed_beats.size();
      endfunction
   endclass

   dechunk_scoreboard model = new();

   logic [7:0]  stream_q[$];
   int unsigned idle_pct;
   int unsigned stall_pct;
   int          hold_cycles;

   http_body_dechunker #(.COUNT_WIDTH(COUNT_WIDTH)) uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_byte       (req_in_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_payload_valid (rsp_payload_valid),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_body_done     (rsp_body_done),
      .rsp_error_code    (rsp_error_code),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit well above the slowest legal run.
   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // Receiver: optional long hold-off, otherwise random stalls.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_cycles--;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   // Both handshakes are sampled at the rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            model.match_beat(rsp_payload_valid, rsp_payload_byte, rsp_body_done,
                             rsp_error_code);
         if (req_valid && !req_stall)
            model.note_byte(req_in_byte);
      end
   end

   // Register write: setup cycle, then access cycle until pready.
   task automatic csr_write(reg_index_type idx, logic [31:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      model.set_reg(idx, value);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Offer every queued byte as one beat each, with random sender gaps.
   task automatic drive_stream();
      logic [7:0] b;
      while (stream_q.size() > 0) begin
         b = stream_q.pop_front();
         while ($urandom_range(99) < idle_pct) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
         @(negedge clock);
         req_valid   <= 1'b1;
         req_in_byte <= b;
         do @(posedge clock); while (req_stall);
      end
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // Wait until every owed beat has arrived, then let the pipeline drain.
   task automatic settle();
      while (model.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Append one byte to the end of the stream being built.
   function automatic void append_byte(logic [7:0] b);
      stream_q.insert(stream_q.size(), b);
   endfunction

   // Append a chunk size in hex, most significant digit first, random letter case.
   function automatic void push_hex(logic [31:0] v);
      int         top;
      logic [3:0] d;
      top = 7;
      while (top > 0 && v[4*top +: 4] == 0) top--;
      for (int i = top; i >= 0; i--) begin
         d = v[4*i +: 4];
         if (d < HEX_TEN)
            append_byte(CHR_DIG_0 + 8'(d));
         else
            append_byte(($urandom_range(1) ? CHR_UP_A : CHR_LO_A) + 8'(d - HEX_TEN));
      end
   endfunction

   function automatic logic [7:0] other_than(logic [7:0] x);
      logic [7:0] b;
      do b = 8'($urandom_range(255)); while (b == x);
      return b;
   endfunction

   function automatic void push_random(int n);
      repeat (n) append_byte(8'($urandom_range(255)));
   endfunction

   // Build a chunked body of about target bytes; a flaw ends it early.
   function automatic void build_chunked(int target, bit allow_flaw);
      flaw_kind_type flaw;
      logic [31:0]   size;
      logic [7:0]    b;
      while (stream_q.size() < target) begin
         size = ($urandom_range(9) == 0) ? $urandom_range(255, 17) : $urandom_range(16, 1);
         flaw = FLAW_NONE;
         if (allow_flaw && $urandom_range(99) < 12)
            flaw = flaw_kind_type'($urandom_range(5, 1));
         if ($urandom_range(3) == 0)
            repeat ($urandom_range(3, 1)) append_byte(CHR_DIG_0);
         if (flaw == FLAW_OVERFLOW) begin
            // Eight digits with a nonzero top digit, then one digit too many.
            push_hex({4'($urandom_range(15, 1)), 28'($urandom)});
            push_hex(32'($urandom_range(15)));
            push_random(2);
            return;
         end
         push_hex(size);
         if (flaw == FLAW_HEX) begin
            do b = 8'($urandom_range(255)); while (hex_of(b) >= 0 || b == CHR_CR);
            append_byte(b);
            push_random(2);
            return;
         end
         append_byte(CHR_CR);
         if (flaw == FLAW_SIZE_LF) begin
            append_byte(other_than(CHR_LF));
            push_random(2);
            return;
         end
         append_byte(CHR_LF);
         push_random(size);
         if (flaw == FLAW_DATA_CR) begin
            append_byte(other_than(CHR_CR));
            push_random(2);
            return;
         end
         append_byte(CHR_CR);
         if (flaw == FLAW_DATA_LF) begin
            append_byte(other_than(CHR_LF));
            push_random(2);
            return;
         end
         append_byte(CHR_LF);
      end
      // Last chunk: explicit zero size or an empty size line.
      if ($urandom_range(1)) append_byte(CHR_DIG_0);
      append_byte(CHR_CR);
      append_byte(CHR_LF);
      if ($urandom_range(2) == 0) push_random(1);
   endfunction

   initial begin
      int          total;
      int          phase_no;
      int          choice;
      bit          hold;
      logic        cur_mode;
      logic [31:0] cur_len;

      reset       = 1'b1;
      req_valid   = 1'b0;
      req_in_byte = '0;
      psel        = 1'b0;
      penable     = 1'b0;
      pwrite      = 1'b0;
      paddr       = '0;
      pwdata      = '0;
      idle_pct    = 0;
      stall_pct   = 0;
      hold_cycles = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Out of reset the length is zero, so the body is already done.
      stream_q = '{8'h00, 8'hFF};
      drive_stream();
      settle();

      // Two payload bytes at the byte extremes, then one byte too many.
      csr_write(REG_CONTENT_LENGTH, 32'd2);
      stream_q = '{8'hFF, 8'h00, 8'h5A};
      drive_stream();
      settle();

      // One chunk of two bytes, then an empty size line ends the body.
      csr_write(REG_CHUNKED_MODE, 32'd1);
      stream_q = '{8'h32, CHR_CR, CHR_LF, 8'h80, 8'h7F, CHR_CR, CHR_LF, CHR_CR, CHR_LF};
      drive_stream();
      settle();

      // Non-hex character in the size.
      csr_write(REG_CHUNKED_MODE, 32'd1);
      stream_q = '{8'h47};
      drive_stream();
      settle();

      // Nine size digits: the ninth carries out of the count.
      csr_write(REG_CHUNKED_MODE, 32'd1);
      stream_q = '{8'h31, CHR_DIG_0, CHR_DIG_0, CHR_DIG_0, CHR_DIG_0,
                   CHR_DIG_0, CHR_DIG_0, CHR_DIG_0, CHR_DIG_0};
      drive_stream();
      settle();

      // Size CR followed by something other than LF.
      csr_write(REG_CHUNKED_MODE, 32'd1);
      stream_q = '{8'h31, CHR_CR, 8'h41};
      drive_stream();
      settle();

      cur_mode = 1'b1;
      cur_len  = 32'd2;

      // Random phases, rotating through the idling patterns.
      total    = 0;
      phase_no = 0;
      while (total < 1550) begin
         case (phase_no % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 75; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 75; end
            default: begin idle_pct = 19; stall_pct = 19; end
         endcase
         hold = (phase_no % 4 == 0) && (phase_no >= 4);

         // New register settings; the first two phases hit the length extremes.
         if (phase_no < 2) begin
            cur_mode = 1'b0;
            cur_len  = (phase_no == 0) ? 32'hFFFF_FFFF : 32'd0;
            csr_write(REG_CHUNKED_MODE, {31'd0, cur_mode});
            csr_write(REG_CONTENT_LENGTH, cur_len);
         end else begin
            choice   = hold ? 2 : $urandom_range(3);
            cur_mode = hold ? 1'b1 : 1'($urandom_range(1));
            if (choice != 0) begin
               case ($urandom_range(19))
                  0:       cur_len = 32'd0;
                  1:       cur_len = 32'd1;
                  2:       cur_len = 32'hFFFF_FFFF;
                  3:       cur_len = $urandom;
                  default: cur_len = $urandom_range(120, 2);
               endcase
            end
            case (choice)
               0: csr_write(REG_CHUNKED_MODE, {31'd0, cur_mode});
               1: csr_write(REG_CONTENT_LENGTH, cur_len);
               2: begin
                  csr_write(REG_CHUNKED_MODE, {31'd0, cur_mode});
                  csr_write(REG_CONTENT_LENGTH, cur_len);
               end
               default: begin
                  csr_write(REG_CONTENT_LENGTH, cur_len);
                  csr_write(REG_CHUNKED_MODE, {31'd0, cur_mode});
               end
            endcase
         end

         if (cur_mode)
            build_chunked($urandom_range(120, 60), !hold);
         else if (cur_len <= 120)
            push_random(int'(cur_len) + $urandom_range(3, 1));
         else
            push_random($urandom_range(120, 60));

         total += stream_q.size();
         // Long receiver hold-off while the sender keeps offering bytes.
         if (hold) hold_cycles = 150;
         drive_stream();
         settle();
         phase_no++;
      end

      if (model.fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
